// ===== hdl/bpfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_pkg
// shared constants and types for the buffer pool frame manager
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int FRAMES  = 16;
  localparam int FW      = $clog2(FRAMES);
  localparam int PIN_W   = 16;
  localparam int META_W  = PIN_W + 1;

  typedef enum logic [1:0] {
    FN_FETCH  = 2'd0,
    FN_NEW    = 2'd1,
    FN_UNPIN  = 2'd2,
    FN_DELETE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    LRU_NONE   = 2'd0,
    LRU_REMOVE = 2'd1,
    LRU_PUSH   = 2'd2,
    LRU_POP    = 2'd3
  } lru_op_t;

  typedef struct packed {
    lru_op_t         op;
    logic [FW-1:0]   frame;
  } lru_cmd_t;

  typedef struct packed {
    logic [FW:0]     len;
    logic [FW-1:0]   tail;
  } lru_stat_t;

endpackage

// ===== hdl/bpfm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bpfm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bpfm_lru.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_lru
// lru list of unpinned frames, entry 0 most recent
// ----------------------------------------------------------------------------
module bpfm_lru import bpfm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lru_cmd_t  cmd,
  output lru_stat_t stat
);

  logic [FW-1:0] ord_r   [FRAMES];
  logic [FW-1:0] ord_nxt [FRAMES];
  logic [FW:0]   len_r, len_nxt;
  logic [FW-1:0] rem_ord [FRAMES];
  logic [FW:0]   rem_len;
  logic          found;
  logic [FW-1:0] pos;
  logic [FW:0]   tail_idx;

  assign tail_idx  = len_r - 1'b1;
  assign stat.len  = len_r;
  assign stat.tail = ord_r[tail_idx[FW-1:0]];

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!found && ((FW+1)'(i) < len_r) && ord_r[i] == cmd.frame) begin
        found = 1'b1;
        pos   = FW'(i);
      end
    end
    for (int j = 0; j < FRAMES; j++) begin
      if (found && FW'(j) >= pos && j < FRAMES - 1) begin
        rem_ord[j] = ord_r[(j + 1) % FRAMES];
      end else begin
        rem_ord[j] = ord_r[j];
      end
    end
    rem_len = found ? len_r - 1'b1 : len_r;

    ord_nxt = ord_r;
    len_nxt = len_r;
    case (cmd.op)
      LRU_REMOVE: begin
        ord_nxt = rem_ord;
        len_nxt = rem_len;
      end
      LRU_PUSH: begin
        ord_nxt = rem_ord;
        len_nxt = rem_len;
        if (rem_len < (FW+1)'(FRAMES)) begin
          ord_nxt[0] = cmd.frame;
          for (int j = 1; j < FRAMES; j++) begin
            ord_nxt[j] = rem_ord[j-1];
          end
          len_nxt = rem_len + 1'b1;
        end
      end
      LRU_POP: begin
        if (len_r != '0) begin
          len_nxt = len_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ord_r <= ord_nxt;
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

endmodule

// ===== hdl/buffer_pool_frame_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager
// page frame manager with free fifo, lru replacer and page lookup
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    in_func, in_page_number, in_mark_dirty
// out      out  out_valid / out_ready  out_status, out_frame_index, out_page_out,
//                                      out_was_resident
//
// each request passes through accept, lookup plus memory read, then execute with
// write back; the pin/dirty ram read-modify-write sets these steps
// the result sits in an output register, so the next request is accepted
// while it waits; execute stalls only while that register is still full
// reset is synchronous; no clearing pass, the free fifo ram reads its
// reset contents through per-entry written flags
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager import bpfm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic signed [31:0] in_page_number,
  input  logic        in_mark_dirty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [3:0]  out_frame_index,
  output logic [30:0] out_page_out,
  output logic        out_was_resident
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // request registers
  logic [1:0]    func_r;
  logic [31:0]   pg_r;
  logic          dirty_r;
  logic          hit_r;
  logic [FW-1:0] hit_idx_r;

  // resident page table, searched in parallel
  logic          valid_r   [FRAMES];
  logic          valid_nxt [FRAMES];
  logic [31:0]   page_r    [FRAMES];
  logic          page_we;
  logic [FW-1:0] page_wa;
  logic [31:0]   page_wd;

  // free fifo pointers and written flags
  logic [FW-1:0] fhead_r, fhead_nxt;
  logic [FW:0]   fcnt_r, fcnt_nxt;
  logic          fwr_r [FRAMES];
  logic          fwr_q_r;
  logic [FW-1:0] fhead_q_r;
  logic [FW:0]   ftail_sum;
  logic [FW-1:0] ftail;
  logic [FW-1:0] fifo_q;
  logic          fifo_we;
  logic [FW-1:0] fifo_wd;
  logic [FW-1:0] free_frame;

  logic [30:0]   next_page_r, next_page_nxt;

  // pin count and dirty mark ram
  logic [META_W-1:0] meta_q;
  logic              meta_we;
  logic [FW-1:0]     meta_wa;
  logic [META_W-1:0] meta_wd;
  logic [PIN_W-1:0]  pins_q;
  logic              mdirty_q;

  // lookup
  logic          cam_hit;
  logic [FW-1:0] cam_idx;

  lru_cmd_t  lru_cmd;
  lru_stat_t lru_stat;

  // output register
  logic          out_valid_r;
  logic          ostat_r, ores_r;
  logic [3:0]    ofidx_r;
  logic [30:0]   opage_r;
  logic          ostat, ores;
  logic [3:0]    ofidx;
  logic [30:0]   opage;

  logic          exec_go;
  logic          neg;
  logic          take_ok;
  logic          from_fifo;
  logic [FW-1:0] take_f;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = ostat_r;
  assign out_frame_index  = ofidx_r;
  assign out_page_out     = opage_r;
  assign out_was_resident = ores_r;

  assign pins_q   = meta_q[PIN_W-1:0];
  assign mdirty_q = meta_q[META_W-1];
  assign neg      = pg_r[31];
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // take a frame: free fifo first, else evict the lru tail
  // unwritten fifo entries hold their own index
  assign free_frame = fwr_q_r ? fifo_q : fhead_q_r;
  assign from_fifo  = (fcnt_r != '0);
  assign take_ok    = from_fifo || (lru_stat.len != '0);
  assign take_f     = from_fifo ? free_frame : lru_stat.tail;
  assign ftail_sum  = {1'b0, fhead_r} + fcnt_r;
  assign ftail      = (ftail_sum >= (FW+1)'(FRAMES)) ?
                      FW'(ftail_sum - (FW+1)'(FRAMES)) : ftail_sum[FW-1:0];

  bpfm_ram #(.W(META_W), .D(FRAMES)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_wa),
    .wdata (meta_wd),
    .re    (state_r == S_READ),
    .raddr (cam_idx),
    .rdata (meta_q)
  );

  bpfm_ram #(.W(FW), .D(FRAMES)) u_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (ftail),
    .wdata (fifo_wd),
    .re    (state_r == S_READ),
    .raddr (fhead_r),
    .rdata (fifo_q)
  );

  bpfm_lru u_lru (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (lru_cmd),
    .stat  (lru_stat)
  );

  // parallel page lookup, lowest matching frame wins
  always_comb begin
    cam_hit = 1'b0;
    cam_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (valid_r[i] && page_r[i] == pg_r) begin
        cam_hit = 1'b1;
        cam_idx = FW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    fhead_nxt     = fhead_r;
    fcnt_nxt      = fcnt_r;
    next_page_nxt = next_page_r;
    page_we       = 1'b0;
    page_wa       = take_f;
    page_wd       = pg_r;
    meta_we       = 1'b0;
    meta_wa       = hit_idx_r;
    meta_wd       = meta_q;
    fifo_we       = 1'b0;
    fifo_wd       = hit_idx_r;
    lru_cmd.op    = LRU_NONE;
    lru_cmd.frame = hit_idx_r;
    ostat         = 1'b1;
    ofidx         = '0;
    opage         = pg_r[30:0];
    ores          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
          case (func_r)
            FN_FETCH: begin
              if (!neg) begin
                if (hit_r) begin
                  if (pins_q != {PIN_W{1'b1}}) begin
                    meta_we    = 1'b1;
                    meta_wd    = {mdirty_q, pins_q + 1'b1};
                    lru_cmd.op = LRU_REMOVE;
                    ostat      = 1'b0;
                    ofidx      = 4'(hit_idx_r);
                    ores       = 1'b1;
                  end
                end else if (take_ok) begin
                  if (from_fifo) begin
                    fhead_nxt = (fhead_r == FW'(FRAMES - 1)) ? '0 : fhead_r + 1'b1;
                    fcnt_nxt  = fcnt_r - 1'b1;
                  end else begin
                    lru_cmd.op = LRU_POP;
                  end
                  valid_nxt[take_f] = 1'b1;
                  page_we = 1'b1;
                  meta_we = 1'b1;
                  meta_wa = take_f;
                  meta_wd = {1'b0, PIN_W'(1)};
                  ostat   = 1'b0;
                  ofidx   = 4'(take_f);
                end
              end
            end
            FN_NEW: begin
              opage = '0;
              if (take_ok) begin
                if (from_fifo) begin
                  fhead_nxt = (fhead_r == FW'(FRAMES - 1)) ? '0 : fhead_r + 1'b1;
                  fcnt_nxt  = fcnt_r - 1'b1;
                end else begin
                  lru_cmd.op = LRU_POP;
                end
                next_page_nxt = next_page_r + 1'b1;
                // an older frame holding the same id loses its mapping
                for (int i = 0; i < FRAMES; i++) begin
                  if (valid_r[i] && page_r[i] == {1'b0, next_page_r}) begin
                    valid_nxt[i] = 1'b0;
                  end
                end
                valid_nxt[take_f] = 1'b1;
                page_we = 1'b1;
                page_wd = {1'b0, next_page_r};
                meta_we = 1'b1;
                meta_wa = take_f;
                meta_wd = {1'b0, PIN_W'(1)};
                ostat   = 1'b0;
                ofidx   = 4'(take_f);
                opage   = next_page_r;
              end
            end
            FN_UNPIN: begin
              if (!neg && hit_r) begin
                meta_we = 1'b1;
                meta_wd = {mdirty_q | dirty_r, pins_q};
                if (pins_q != '0) begin
                  meta_wd = {mdirty_q | dirty_r, pins_q - 1'b1};
                  if (pins_q == PIN_W'(1)) begin
                    lru_cmd.op = LRU_PUSH;
                  end
                  ostat = 1'b0;
                end
              end
            end
            FN_DELETE: begin
              if (!neg) begin
                if (!hit_r) begin
                  ostat = 1'b0;
                end else if (pins_q == '0) begin
                  lru_cmd.op = LRU_REMOVE;
                  valid_nxt[hit_idx_r] = 1'b0;
                  meta_we = 1'b1;
                  meta_wd = '0;
                  if (fcnt_r < (FW+1)'(FRAMES)) begin
                    fifo_we  = 1'b1;
                    fcnt_nxt = fcnt_r + 1'b1;
                  end
                  ostat = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r  <= in_func;
      pg_r    <= in_page_number;
      dirty_r <= in_mark_dirty;
    end
    if (state_r == S_READ) begin
      hit_r     <= cam_hit;
      hit_idx_r <= cam_idx;
      fwr_q_r   <= fwr_r[fhead_r];
      fhead_q_r <= fhead_r;
    end
    if (page_we) begin
      page_r[page_wa] <= page_wd;
    end
    if (exec_go) begin
      ostat_r <= ostat;
      ofidx_r <= ofidx;
      opage_r <= opage;
      ores_r  <= ores;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fhead_r     <= '0;
      fcnt_r      <= (FW+1)'(FRAMES);
      next_page_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        valid_r[i] <= 1'b0;
        fwr_r[i]   <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      fhead_r     <= fhead_nxt;
      fcnt_r      <= fcnt_nxt;
      next_page_r <= next_page_nxt;
      if (fifo_we) begin
        fwr_r[ftail] <= 1'b1;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/bpfm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_checker
// port level checks on the frame manager result channel
// ----------------------------------------------------------------------------
module bpfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [3:0]  out_frame_index,
  input logic        out_was_resident
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_index))
    else $error("result word dropped or changed while stalled");

  // a resident hit is always a success
  a_res_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_resident |-> !out_status)
    else $error("resident hit reported as failure");

  // failed requests carry frame zero
  a_fail_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_frame_index == 4'd0)
    else $error("failure with nonzero frame index");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind buffer_pool_frame_manager bpfm_checker u_bpfm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_frame_index  (out_frame_index),
  .out_was_resident (out_was_resident)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the buffer pool frame manager: a directed table of requests, then
// random fetch/new/unpin/delete traffic on a small page set, every result
// compared with an in-bench frame table, free fifo and lru list
// ----------------------------------------------------------------------------
module tb_top;
  import bpfm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS   = 1250;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic signed [31:0] in_page_number;
  logic        in_mark_dirty;
  logic        out_valid;
  logic        out_ready;
  logic        out_status;
  logic [3:0]  out_frame_index;
  logic [30:0] out_page_out;
  logic        out_was_resident;

  buffer_pool_frame_manager dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_page_number   (in_page_number),
    .in_mark_dirty    (in_mark_dirty),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_frame_index  (out_frame_index),
    .out_page_out     (out_page_out),
    .out_was_resident (out_was_resident)
  );

  // one result word
  typedef struct packed {
    logic        status;
    logic [3:0]  frame_index;
    logic [30:0] page_out;
    logic        was_resident;
  } reply_t;

  // one request word; chk set means the typed-in reply is compared as well
  typedef struct {
    func_t       fn;
    logic [31:0] page;
    logic        dirty;
    logic        chk;
    reply_t      reply;
  } req_row_t;

  // frame table mirror
  logic        fr_valid [FRAMES];
  logic [31:0] fr_page  [FRAMES];
  logic [15:0] fr_pins  [FRAMES];
  logic        fr_dirty [FRAMES];
  int          recent_q [$];   // entry 0 is most recent
  int          spare_q  [$];
  logic [30:0] page_counter;

  reply_t      pending_replies[$];
  int          error_count;
  int          idle_cycles;
  bit          sender_done;
  bit          hold_off;
  bit          calm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic int find_page(input logic [31:0] pg);
    for (int i = 0; i < FRAMES; i++)
      if (fr_valid[i] && fr_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic void drop_from_lru(input int f);
    for (int i = 0; i < recent_q.size(); i++)
      if (recent_q[i] == f) begin
        recent_q.delete(i);
        return;
      end
  endfunction

  // free fifo first, then the least recently unpinned frame
  function automatic int grab_frame();
    int f;
    if (spare_q.size() > 0) begin
      f = spare_q[0];
      spare_q.delete(0);
      return f;
    end
    if (recent_q.size() > 0) begin
      f = recent_q[recent_q.size() - 1];
      recent_q.delete(recent_q.size() - 1);
      fr_valid[f] = 1'b0;
      return f;
    end
    return -1;
  endfunction

  function automatic void bind_frame(input int f, input logic [31:0] pg);
    drop_from_lru(f);
    fr_valid[f] = 1'b1;
    fr_page[f]  = pg;
    fr_pins[f]  = 16'd1;
    fr_dirty[f] = 1'b0;
  endfunction

  function automatic reply_t predict_reply(input func_t fn, input logic [31:0] pg,
                                           input logic dirty);
    reply_t r;
    int f;
    logic [30:0] id;
    r = '{status: 1'b1, frame_index: 4'd0, page_out: pg[30:0], was_resident: 1'b0};
    case (fn)
      FN_FETCH: begin
        if (!pg[31]) begin
          f = find_page(pg);
          if (f >= 0) begin
            if (fr_pins[f] != 16'hffff) begin
              fr_pins[f]++;
              drop_from_lru(f);
              r.status = 1'b0;
              r.frame_index = f[3:0];
              r.was_resident = 1'b1;
            end
          end else begin
            f = grab_frame();
            if (f >= 0) begin
              bind_frame(f, pg);
              r.status = 1'b0;
              r.frame_index = f[3:0];
            end
          end
        end
      end
      FN_NEW: begin
        r.page_out = '0;
        f = grab_frame();
        if (f >= 0) begin
          id = page_counter;
          page_counter++;
          // an older frame holding the same id loses its mapping
          for (int i = 0; i < FRAMES; i++)
            if (fr_valid[i] && fr_page[i] == {1'b0, id}) fr_valid[i] = 1'b0;
          bind_frame(f, {1'b0, id});
          r.status = 1'b0;
          r.frame_index = f[3:0];
          r.page_out = id;
        end
      end
      FN_UNPIN: begin
        f = pg[31] ? -1 : find_page(pg);
        if (f >= 0) begin
          if (dirty) fr_dirty[f] = 1'b1;
          if (fr_pins[f] != 0) begin
            fr_pins[f]--;
            if (fr_pins[f] == 0) begin
              drop_from_lru(f);
              recent_q.insert(0, f);
            end
            r.status = 1'b0;
          end
        end
      end
      default: begin
        if (!pg[31]) begin
          f = find_page(pg);
          if (f < 0) begin
            r.status = 1'b0;
          end else if (fr_pins[f] == 0) begin
            drop_from_lru(f);
            fr_valid[f] = 1'b0;
            fr_dirty[f] = 1'b0;
            if (spare_q.size() < FRAMES) spare_q.insert(spare_q.size(), f);
            r.status = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  // send one request word, wait for acceptance; valid stays up between
  // back to back words and drops only while idling
  task automatic send_request(input func_t fn, input logic [31:0] pg, input logic dirty,
                              input logic chk, input reply_t want);
    reply_t r;
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= fn;
    in_page_number <= pg;
    in_mark_dirty  <= dirty;
    do @(posedge clk); while (!in_ready);
    r = predict_reply(fn, pg, dirty);
    if (chk && r != want) report_mismatch("table row", {31'd0, r.status}, {31'd0, want.status});
    pending_replies.insert(pending_replies.size(), r);
  endtask

  // pick a page id mostly from a small hot set so hits and evictions happen
  function automatic logic [31:0] pick_page();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 32'($urandom_range(24));
    if (sel < 78) return {1'b1, 31'($urandom)};
    if (sel < 84) return 32'h7fffffff - 32'($urandom_range(3));
    return {1'b0, 31'($urandom)};
  endfunction

  initial begin
    req_row_t rows[$];
    reply_t   ok0, fail0;
    func_t    fn;
    int       pct;
    fail0 = '{status: 1'b1, frame_index: 4'd0, page_out: '0, was_resident: 1'b0};
    ok0   = '{status: 1'b0, frame_index: 4'd0, page_out: '0, was_resident: 1'b0};

    for (int i = 0; i < FRAMES; i++) begin
      fr_valid[i] = 1'b0;
      fr_page[i]  = '0;
      fr_pins[i]  = '0;
      fr_dirty[i] = 1'b0;
      spare_q.insert(spare_q.size(), i);
    end
    page_counter   = '0;
    error_count    = 0;
    sender_done    = 1'b0;
    calm           = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FN_FETCH;
    in_page_number = '0;
    in_mark_dirty  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: typed replies where obvious, the rest from the predictor
    rows.insert(rows.size(), '{FN_NEW, 32'd0, 1'b0, 1'b1, ok0});
    rows.insert(rows.size(), '{FN_FETCH, 32'hffffffff, 1'b0, 1'b1,
                               '{1'b1, 4'd0, 31'h7fffffff, 1'b0}});
    rows.insert(rows.size(), '{FN_FETCH, 32'h7fffffff, 1'b0, 1'b1,
                               '{1'b0, 4'd1, 31'h7fffffff, 1'b0}});
    rows.insert(rows.size(), '{FN_FETCH, 32'h7fffffff, 1'b0, 1'b1,
                               '{1'b0, 4'd1, 31'h7fffffff, 1'b1}});
    rows.insert(rows.size(), '{FN_UNPIN, 32'h80000000, 1'b1, 1'b1, fail0});
    rows.insert(rows.size(), '{FN_UNPIN, 32'd999, 1'b0, 1'b1,
                               '{1'b1, 4'd0, 31'd999, 1'b0}});
    rows.insert(rows.size(), '{FN_DELETE, 32'd999, 1'b0, 1'b1,
                               '{1'b0, 4'd0, 31'd999, 1'b0}});
    rows.insert(rows.size(), '{FN_DELETE, 32'h7fffffff, 1'b0, 1'b1,
                               '{1'b1, 4'd0, 31'h7fffffff, 1'b0}});
    rows.insert(rows.size(), '{FN_DELETE, 32'hffffffff, 1'b0, 1'b1,
                               '{1'b1, 4'd0, 31'h7fffffff, 1'b0}});
    rows.insert(rows.size(), '{FN_UNPIN, 32'h7fffffff, 1'b1, 1'b0, ok0});
    rows.insert(rows.size(), '{FN_UNPIN, 32'h7fffffff, 1'b0, 1'b0, ok0});
    rows.insert(rows.size(), '{FN_UNPIN, 32'h7fffffff, 1'b1, 1'b0, ok0});   // zero pins
    rows.insert(rows.size(), '{FN_DELETE, 32'h7fffffff, 1'b0, 1'b0, ok0});
    rows.insert(rows.size(), '{FN_UNPIN, 32'd0, 1'b0, 1'b0, ok0});
    foreach (rows[i])
      send_request(rows[i].fn, rows[i].page, rows[i].dirty, rows[i].chk, rows[i].reply);

    // fill every frame, then new pages fail until something is unpinned
    for (int i = 0; i < FRAMES + 2; i++) send_request(FN_NEW, '0, 1'b0, 1'b0, ok0);
    for (int i = 0; i < 4; i++) send_request(FN_UNPIN, 32'(i + 1), 1'b1, 1'b0, ok0);
    send_request(FN_FETCH, 32'd500, 1'b0, 1'b0, ok0);   // evicts lru victim

    // sender pause until everything drains
    in_valid <= 1'b0;
    wait (pending_replies.size() == 0);
    @(posedge clk);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 400 && n < 550);
      pct = $urandom_range(99);
      fn = pct < 35 ? FN_FETCH : pct < 50 ? FN_NEW : pct < 85 ? FN_UNPIN : FN_DELETE;
      send_request(fn, pick_page(), 1'($urandom), 1'b0, ok0);
    end
    // pin overflow on one page would take 0xffff fetches, too long for this
    // run, so the saturated pin count is not driven by this bench
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // receiver with random stalls and at least one long hold-off
  initial begin
    int rx_cycles;
    bit held_once;
    out_ready = 1'b0;
    hold_off  = 1'b0;
    rx_cycles = 0;
    held_once = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (!hold_off && !calm && pending_replies.size() != 0 &&
          ((!held_once && rx_cycles >= 300) || $urandom_range(199) == 0)) begin
        hold_off  = 1'b1;
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  // result checker
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected word", {31'd0, out_status}, '0);
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (out_status !== want.status)
          report_mismatch("status", {31'd0, out_status}, {31'd0, want.status});
        if (out_frame_index !== want.frame_index)
          report_mismatch("frame_index", {28'd0, out_frame_index},
                          {28'd0, want.frame_index});
        if (out_page_out !== want.page_out)
          report_mismatch("page_out", {1'b0, out_page_out}, {1'b0, want.page_out});
        if (out_was_resident !== want.was_resident)
          report_mismatch("was_resident", {31'd0, out_was_resident},
                          {31'd0, want.was_resident});
      end
    end
  end

  // watchdog on cycles with no handshake, and the end of run
  initial begin
    idle_cycles = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL buffer_pool_frame_manager");
        $finish;
      end
      if (sender_done && pending_replies.size() == 0) begin
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
          $display("PASS buffer_pool_frame_manager");
        end else begin
          $display("FAIL buffer_pool_frame_manager");
        end
        $finish;
      end
    end
  end

endmodule
